>>> rtl/core/cft_pkg.sv
// package for the csv field tokenizer: request types, phase codes and constants
package cft_pkg;

    localparam int MAX_COLUMNS = 256;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 18;
    localparam int COL_W  = 8;
    localparam int ERR_W  = 2;
    localparam int CFG_W  = 18;
    localparam int IDX_W  = 2;

    // column counter saturates at the smaller of the column limit and its own range
    localparam int COL_CAP_INT = (MAX_COLUMNS - 1 < (1 << COL_W) - 1) ?
                                 (MAX_COLUMNS - 1) : ((1 << COL_W) - 1);
    localparam logic [COL_W-1:0] COL_CAP = COL_W'(COL_CAP_INT);

    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'd0;
    localparam logic [BYTE_W-1:0] DELIM_RST  = 8'd44;
    localparam logic [BYTE_W-1:0] QUOTE_RST  = 8'd34;
    localparam logic [LEN_W-1:0]  MAXLEN_RST = LEN_W'(128 * 1024);

    localparam logic [IDX_W-1:0] CFG_DELIM  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_QUOTE  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAXLEN = 2'd2;

    localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LONG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NUL  = 2'd2;

    typedef enum logic [2:0] {
        PH_START_RECORD = 3'd0,
        PH_START_FIELD  = 3'd1,
        PH_IN_FIELD     = 3'd2,
        PH_IN_QUOTED    = 3'd3,
        PH_QUOTE_SEEN   = 3'd4
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_input;
    } t_in;

    typedef struct packed {
        logic              char_valid;
        logic [BYTE_W-1:0] out_byte;
        logic              field_end;
        logic              record_end;
        logic [COL_W-1:0]  column_index;
        logic [ERR_W-1:0]  error_code;
    } t_out;

    typedef struct packed {
        logic [BYTE_W-1:0] delimiter_char;
        logic [BYTE_W-1:0] quote_char;
        logic [LEN_W-1:0]  max_field_length;
    } t_cfg;

    typedef struct packed {
        t_phase            phase;
        logic [LEN_W-1:0]  field_length;
        logic [COL_W-1:0]  column_count;
    } t_state;

endpackage

>>> rtl/core/cft_step.sv
// one tokenizer step: next parse state and the result for one byte request
module cft_step (
    input  cft_pkg::t_in    i_item,
    input  cft_pkg::t_cfg   i_cfg,
    input  cft_pkg::t_state i_state,
    output cft_pkg::t_state o_state,
    output logic            o_has_result,
    output cft_pkg::t_out   o_result
);
    import cft_pkg::*;

    logic   nl;
    logic   is_quote;
    logic   is_delim;
    logic   do_end;
    logic   end_rec;
    logic   do_add;
    t_phase add_phase;
    t_phase hold_phase;

    assign nl       = (i_item.data_byte == CHAR_LF) || (i_item.data_byte == CHAR_CR);
    assign is_quote = (i_item.data_byte == i_cfg.quote_char);
    assign is_delim = (i_item.data_byte == i_cfg.delimiter_char);

    // decide the action from phase and byte class
    always_comb begin
        do_end     = 1'b0;
        end_rec    = 1'b0;
        do_add     = 1'b0;
        add_phase  = PH_IN_FIELD;
        hold_phase = i_state.phase;
        case (i_state.phase)
            PH_IN_FIELD: begin
                if (nl) begin
                    do_end  = 1'b1;
                    end_rec = 1'b1;
                end else if (is_delim) begin
                    do_end = 1'b1;
                end else begin
                    do_add = 1'b1;
                end
            end
            PH_IN_QUOTED: begin
                if (is_quote) begin
                    hold_phase = PH_QUOTE_SEEN;
                end else begin
                    do_add    = 1'b1;
                    add_phase = PH_IN_QUOTED;
                end
            end
            PH_QUOTE_SEEN: begin
                if (is_quote) begin
                    do_add    = 1'b1;
                    add_phase = PH_IN_QUOTED;
                end else if (is_delim) begin
                    do_end = 1'b1;
                end else if (nl) begin
                    do_end  = 1'b1;
                    end_rec = 1'b1;
                end else begin
                    do_add = 1'b1;
                end
            end
            PH_START_FIELD: begin
                if (nl) begin
                    do_end  = 1'b1;
                    end_rec = 1'b1;
                end else if (is_quote) begin
                    hold_phase = PH_IN_QUOTED;
                end else if (is_delim) begin
                    do_end = 1'b1;
                end else begin
                    do_add = 1'b1;
                end
            end
            default: begin
                // start of record, unused codes too
                hold_phase = PH_START_RECORD;
                if (nl) begin
                    hold_phase = PH_START_RECORD;
                end else if (is_quote) begin
                    hold_phase = PH_IN_QUOTED;
                end else if (is_delim) begin
                    do_end = 1'b1;
                end else begin
                    do_add = 1'b1;
                end
            end
        endcase
    end

    // apply the action
    always_comb begin
        o_state       = i_state;
        o_has_result  = 1'b0;
        o_result      = '0;
        if (i_item.end_of_input) begin
            if (i_state.phase == PH_IN_FIELD || i_state.phase == PH_START_FIELD ||
                i_state.phase == PH_IN_QUOTED || i_state.phase == PH_QUOTE_SEEN) begin
                o_has_result          = 1'b1;
                o_result.field_end    = 1'b1;
                o_result.record_end   = 1'b1;
                o_result.column_index = i_state.column_count;
            end
            o_state.phase        = PH_START_RECORD;
            o_state.field_length = '0;
            o_state.column_count = '0;
        end else if (i_item.data_byte == CHAR_NUL) begin
            o_has_result        = 1'b1;
            o_result.error_code = ERR_NUL;
        end else if (do_end) begin
            o_has_result          = 1'b1;
            o_result.field_end    = 1'b1;
            o_result.record_end   = end_rec;
            o_result.column_index = i_state.column_count;
            o_state.field_length  = '0;
            if (end_rec) begin
                o_state.column_count = '0;
                o_state.phase        = PH_START_RECORD;
            end else begin
                if (i_state.column_count < COL_CAP) begin
                    o_state.column_count = i_state.column_count + COL_W'(1);
                end
                o_state.phase = PH_START_FIELD;
            end
        end else if (do_add) begin
            o_has_result  = 1'b1;
            o_state.phase = add_phase;
            if (i_state.field_length >= i_cfg.max_field_length) begin
                o_result.error_code = ERR_LONG;
            end else begin
                o_state.field_length = i_state.field_length + LEN_W'(1);
                o_result.char_valid  = 1'b1;
                o_result.out_byte    = i_item.data_byte;
            end
        end else begin
            o_state.phase = hold_phase;
        end
    end

endmodule

>>> rtl/core/csv_field_tokenizer.sv
// top level of the csv field tokenizer: input register, step logic, result register
// a byte request is held in the input register, and its result then in the result register
// throughput: one byte request per cycle, sustained, while the result side keeps up
// the byte stream loop is the parse state register, updated once per request in stage one
// reset (synchronous, active low) returns the phase to start of record, clears the
// field length and column count, empties both stages and restores the default registers
module csv_field_tokenizer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // byte request side
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cft_pkg::t_in                i_in_data,
    // result side
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cft_pkg::t_out               o_out_data,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [cft_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [cft_pkg::CFG_W-1:0]   i_cfg_data
);
    import cft_pkg::*;

    // configuration registers
    t_cfg   r_cfg;

    // input register stage
    logic   r_in_valid;
    t_in    r_in;

    // parse state
    t_state r_state;
    t_state n_state;

    // result register stage
    logic   r_out_valid;
    t_out   r_out;

    logic   step_has_result;
    t_out   step_result;
    logic   advance;

    cft_step u_step (
        .i_item       (r_in),
        .i_cfg        (r_cfg),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_has_result (step_has_result),
        .o_result     (step_result)
    );

    // the held request moves on when the result register is free or being emptied;
    // requests that give no result move on all the same and only update state
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    // register writes; the user must do them only while idle, the block itself does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char   <= DELIM_RST;
            r_cfg.quote_char       <= QUOTE_RST;
            r_cfg.max_field_length <= MAXLEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DELIM:  r_cfg.delimiter_char   <= i_cfg_data[BYTE_W-1:0];
                CFG_QUOTE:  r_cfg.quote_char       <= i_cfg_data[BYTE_W-1:0];
                CFG_MAXLEN: r_cfg.max_field_length <= i_cfg_data[LEN_W-1:0];
                default: begin
                    // writes past the register list are dropped
                end
            endcase
        end
    end

    // input register: refilled whenever empty or its request moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // parse state follows each request as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_START_RECORD;
            r_state.field_length <= '0;
            r_state.column_count <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step_has_result;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_has_result) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/cft_checker.sv
// port checker for the csv field tokenizer, bound to the top level
module cft_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input cft_pkg::t_out               o_out_data
);
    import cft_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // a record end always closes a field, never a content byte
    a_rec_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.record_end |->
            o_out_data.field_end && !o_out_data.char_valid)
        else $error("record end without field end");

    // an error result carries neither content nor a field end
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.error_code != ERR_NONE) |->
            !o_out_data.char_valid && !o_out_data.field_end &&
            (o_out_data.error_code == ERR_LONG || o_out_data.error_code == ERR_NUL))
        else $error("error result mixed with content or field end");

    // with the byte side stalled the result side must be the cause
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("byte side stalled with result side free");

endmodule

bind csv_field_tokenizer cft_checker u_cft_checker (.*);
